### src/lrapq_pkg.sv
// Shared widths, codes and controller/datapath interface types for the lazy range-assign tree.
`default_nettype none
package lrapq_pkg;

	localparam int POS_W = 11;
	localparam int LEAVES_DEF = 1024;
	localparam logic [POS_W-1:0] LEAF_COUNT_RST = 11'd1024;

	localparam int NODE_W = 2;
	localparam int VAL_BIT = 1;
	localparam int MARK_BIT = 0;

	localparam logic SLOT_LO = 1'b0;
	localparam logic SLOT_HI = 1'b1;

	localparam logic KIND_ASSIGN = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [2:0] {
		WR_NONE = 3'd0,
		WR_CLEAR = 3'd1,
		WR_ROOT = 3'd2,
		WR_PARENT = 3'd3,
		WR_CHILD_A = 3'd4,
		WR_CHILD_B = 3'd5
	} wr_op_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic slot;
		wr_op_t wr_op;
		logic step;
		logic take_leaf;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic query;
		logic empty;
		logic root_exact;
		logic oob;
		logic act0;
		logic act1;
		logic dup;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

### src/lrapq_req_if.sv
// Request channel: valid/ready handshake carrying one assign or query request.
`default_nettype none
interface lrapq_req_if import lrapq_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	logic [POS_W-1:0] range_low;
	logic [POS_W-1:0] range_high;
	logic fill_value;
	logic [POS_W-1:0] position;

	modport source (
		output valid, kind, range_low, range_high, fill_value, position,
		input ready
	);
	modport sink (
		input valid, kind, range_low, range_high, fill_value, position,
		output ready
	);
endinterface
`default_nettype wire

### src/lrapq_res_if.sv
// Result channel: valid/ready handshake carrying the bit read by a query.
`default_nettype none
interface lrapq_res_if import lrapq_pkg::*; ();
	logic valid;
	logic ready;
	logic bit_value;

	modport source (
		output valid, bit_value,
		input ready
	);
	modport sink (
		input valid, bit_value,
		output ready
	);
endinterface
`default_nettype wire

### src/lazy_range_assign_point_query.sv
// Top level of the lazy range-assign, point-query segment tree over one-bit values.
`default_nettype none
// Holds a segment tree of value/mark bit pairs over positions 1 to leaf_count in a node memory of
// 4*LEAVES entries. After reset the block sweeps the memory to zero, one node a cycle, during
// which no request is taken (leaf_count writes are). One request is worked at a time; the
// result register lets the next request in while a result waits. The node memory does one read
// or one write a cycle. The level walk visits each boundary node of a level with a read, a push
// and two child writes, then steps down a level. An empty assign range goes straight back to
// idle, and a whole-tree assign range writes only the root.
module lazy_range_assign_point_query import lrapq_pkg::*; #(
	parameter int LEAVES = LEAVES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [POS_W-1:0] cfg_wdata,
	lrapq_req_if.sink req,
	lrapq_res_if.source res
);

	dp_cmd_t cmd;
	dp_status_t st;
	logic req_ready;

	assign req.ready = req_ready;

	lrapq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req_ready),
		.st(st),
		.cmd(cmd)
	);

	lrapq_dp #(
		.LEAVES(LEAVES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_kind(req.kind),
		.req_range_low(req.range_low),
		.req_range_high(req.range_high),
		.req_fill_value(req.fill_value),
		.req_position(req.position),
		.cmd(cmd),
		.st(st),
		.res_valid(res.valid),
		.res_ready(res.ready),
		.res_bit_value(res.bit_value)
	);

endmodule
`default_nettype wire

### src/lrapq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module lrapq_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic rd_en,
	input wire logic [AW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

### src/lrapq_ctrl.sv
// Controller state machine: clearing pass, level walk over boundary nodes, result hand-off.
`default_nettype none
module lrapq_ctrl import lrapq_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire dp_status_t st,
	output dp_cmd_t cmd
);

	typedef enum logic [12:0] {
		S_CLEAR = 13'b0000000000001,
		S_IDLE = 13'b0000000000010,
		S_START = 13'b0000000000100,
		S_ROOT_WR = 13'b0000000001000,
		S_LEVEL = 13'b0000000010000,
		S_RD = 13'b0000000100000,
		S_PUSH = 13'b0000001000000,
		S_WR_A = 13'b0000010000000,
		S_WR_B = 13'b0000100000000,
		S_STEP = 13'b0001000000000,
		S_LEAF_RD = 13'b0010000000000,
		S_LEAF_WAIT = 13'b0100000000000,
		S_RESULT = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic slot_q, slot_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			slot_q <= SLOT_LO;
		end else begin
			state_q <= state_d;
			slot_q <= slot_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		slot_d = slot_q;
		cmd = '0;
		cmd.wr_op = WR_NONE;
		cmd.slot = slot_q;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_op = WR_CLEAR;
				if (st.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_START;
				end
			end
			S_START: begin
				if (st.query) begin
					state_d = st.oob ? S_RESULT : S_LEVEL;
				end else if (st.empty) begin
					state_d = S_IDLE;
				end else if (st.root_exact) begin
					state_d = S_ROOT_WR;
				end else begin
					state_d = S_LEVEL;
				end
			end
			S_ROOT_WR: begin
				cmd.wr_op = WR_ROOT;
				state_d = S_IDLE;
			end
			S_LEVEL: begin
				if (st.act0) begin
					slot_d = SLOT_LO;
					state_d = S_RD;
				end else if (st.act1) begin
					slot_d = SLOT_HI;
					state_d = S_RD;
				end else if (st.query) begin
					state_d = S_LEAF_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				cmd.wr_op = WR_PARENT;
				state_d = S_WR_A;
			end
			S_WR_A: begin
				cmd.wr_op = WR_CHILD_A;
				state_d = S_WR_B;
			end
			S_WR_B: begin
				cmd.wr_op = WR_CHILD_B;
				if (slot_q == SLOT_LO && st.act1 && !st.dup) begin
					slot_d = SLOT_HI;
					state_d = S_RD;
				end else begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d = S_LEVEL;
			end
			S_LEAF_RD: begin
				cmd.rd = 1'b1;
				cmd.slot = SLOT_LO;
				state_d = S_LEAF_WAIT;
			end
			S_LEAF_WAIT: begin
				cmd.take_leaf = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### src/lrapq_dp.sv
// Datapath: leaf count register, request registers, two boundary walkers, node memory, result register.
`default_nettype none
module lrapq_dp import lrapq_pkg::*; #(
	parameter int LEAVES = LEAVES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [POS_W-1:0] cfg_wdata,
	input wire logic req_kind,
	input wire logic [POS_W-1:0] req_range_low,
	input wire logic [POS_W-1:0] req_range_high,
	input wire logic req_fill_value,
	input wire logic [POS_W-1:0] req_position,
	input wire dp_cmd_t cmd,
	output dp_status_t st,
	output logic res_valid,
	input wire logic res_ready,
	output logic res_bit_value
);

	localparam int DEPTH = 4 * LEAVES;
	localparam int NW = $clog2(DEPTH);
	localparam int POS_MAX = (1 << POS_W) - 1;
	localparam int LEAF_CAP = (LEAVES < POS_MAX) ? LEAVES : POS_MAX;
	localparam logic [POS_W-1:0] LEAF_CAP_W = POS_W'(LEAF_CAP);
	localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
	localparam logic [NW-1:0] ROOT_NODE = NW'(1);
	localparam logic [NW-1:0] LAST_NODE = NW'(DEPTH - 1);

	function automatic logic [POS_W-1:0] mid(input logic [POS_W-1:0] l, input logic [POS_W-1:0] r);
		logic [POS_W:0] s;
		s = {1'b0, l} + {1'b0, r};
		return s[POS_W:1];
	endfunction

	logic [POS_W-1:0] leaf_count_q;
	logic [NW-1:0] clr_cnt_q;
	logic kind_q;
	logic fill_q;
	logic [POS_W-1:0] lo_q, hi_q, n_q;
	logic [NW-1:0] node_q [2];
	logic [POS_W-1:0] tl_q [2];
	logic [POS_W-1:0] tr_q [2];
	logic act_q [2];
	logic res_bit_q;
	logic out_valid_q;
	logic out_bit_q;

	logic [POS_W-1:0] n_now, lo_c, hi_c;
	logic in_query, root_partial;

	logic [NW-1:0] nxt_node [2];
	logic [POS_W-1:0] nxt_tl [2];
	logic [POS_W-1:0] nxt_tr [2];
	logic nxt_act [2];

	logic [NW-1:0] sv;
	logic [POS_W-1:0] stl, s_tr, stm, stm1;
	logic a_exact, b_exact;
	logic q_query;

	logic ram_we, ram_rd;
	logic [NW-1:0] ram_waddr;
	logic [NODE_W-1:0] ram_wdata, ram_rdata;
	logic p_val, p_mark;

	// Request clipping against the current leaf count
	always_comb begin
		if (leaf_count_q == '0) begin
			n_now = POS_ONE;
		end else if (leaf_count_q > LEAF_CAP_W) begin
			n_now = LEAF_CAP_W;
		end else begin
			n_now = leaf_count_q;
		end
		in_query = (req_kind == KIND_QUERY);
		lo_c = (req_range_low == '0) ? POS_ONE : req_range_low;
		hi_c = (req_range_high > n_now) ? n_now : req_range_high;
		root_partial = (lo_c <= hi_c) && !(lo_c == POS_ONE && hi_c == n_now);
	end

	assign q_query = (kind_q == KIND_QUERY);

	// Selected walker slot and its children
	always_comb begin
		sv = node_q[cmd.slot];
		stl = tl_q[cmd.slot];
		s_tr = tr_q[cmd.slot];
		stm = mid(stl, s_tr);
		stm1 = stm + POS_ONE;
		a_exact = !q_query && (lo_q <= stl) && (hi_q >= stm);
		b_exact = !q_query && (lo_q <= stm1) && (hi_q >= s_tr);
	end

	// Next node of each walker
	always_comb begin
		logic [POS_W-1:0] tm, tgt, ctl, ctr;
		logic left;
		for (int i = 0; i < 2; i++) begin
			tm = mid(tl_q[i], tr_q[i]);
			tgt = (i == 0) ? lo_q : hi_q;
			left = (tgt <= tm);
			ctl = left ? tl_q[i] : (tm + POS_ONE);
			ctr = left ? tm : tr_q[i];
			nxt_node[i] = {node_q[i][NW-2:0], !left};
			nxt_tl[i] = ctl;
			nxt_tr[i] = ctr;
			nxt_act[i] = q_query ? (ctl != ctr) : !((lo_q <= ctl) && (hi_q >= ctr));
		end
	end

	assign p_val = ram_rdata[VAL_BIT];
	assign p_mark = ram_rdata[MARK_BIT];

	// Node memory write port
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = sv;
		ram_wdata = '0;
		case (cmd.wr_op)
			WR_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_cnt_q;
			end
			WR_ROOT: begin
				ram_we = 1'b1;
				ram_waddr = ROOT_NODE;
				ram_wdata[VAL_BIT] = fill_q;
				ram_wdata[MARK_BIT] = 1'b1;
			end
			WR_PARENT: begin
				ram_we = p_mark;
				ram_wdata[VAL_BIT] = p_val;
				ram_wdata[MARK_BIT] = 1'b0;
			end
			WR_CHILD_A: begin
				ram_we = p_mark || a_exact;
				ram_waddr = {sv[NW-2:0], 1'b0};
				ram_wdata[VAL_BIT] = a_exact ? fill_q : p_val;
				ram_wdata[MARK_BIT] = 1'b1;
			end
			WR_CHILD_B: begin
				ram_we = p_mark || b_exact;
				ram_waddr = {sv[NW-2:0], 1'b1};
				ram_wdata[VAL_BIT] = b_exact ? fill_q : p_val;
				ram_wdata[MARK_BIT] = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_rd = cmd.rd;

	lrapq_ram #(
		.WIDTH(NODE_W),
		.DEPTH(DEPTH)
	) u_nodes (
		.clk(clk),
		.we(ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en(ram_rd),
		.rd_addr(sv),
		.rd_data(ram_rdata)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_count_q <= LEAF_COUNT_RST;
			clr_cnt_q <= '0;
			act_q[0] <= 1'b0;
			act_q[1] <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				leaf_count_q <= cfg_wdata;
			end
			if (cmd.wr_op == WR_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + NW'(1);
			end
			if (cmd.load) begin
				act_q[0] <= in_query ? (n_now != POS_ONE) : root_partial;
				act_q[1] <= in_query ? 1'b0 : root_partial;
			end else if (cmd.step) begin
				for (int i = 0; i < 2; i++) begin
					if (act_q[i]) begin
						act_q[i] <= nxt_act[i];
					end
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req_kind;
			fill_q <= req_fill_value;
			n_q <= n_now;
			lo_q <= in_query ? req_position : lo_c;
			hi_q <= in_query ? req_position : hi_c;
			res_bit_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				node_q[i] <= ROOT_NODE;
				tl_q[i] <= POS_ONE;
				tr_q[i] <= n_now;
			end
		end else begin
			if (cmd.step) begin
				for (int i = 0; i < 2; i++) begin
					if (act_q[i]) begin
						node_q[i] <= nxt_node[i];
						tl_q[i] <= nxt_tl[i];
						tr_q[i] <= nxt_tr[i];
					end
				end
			end
			if (cmd.take_leaf) begin
				res_bit_q <= p_val;
			end
		end
		if (cmd.out_load) begin
			out_bit_q <= res_bit_q;
		end
	end

	always_comb begin
		st.clr_done = (clr_cnt_q == LAST_NODE);
		st.query = q_query;
		st.empty = (lo_q > hi_q);
		st.root_exact = (lo_q == POS_ONE) && (hi_q == n_q);
		st.oob = (lo_q == '0) || (lo_q > n_q);
		st.act0 = act_q[0];
		st.act1 = act_q[1];
		st.dup = act_q[0] && act_q[1] && (node_q[0] == node_q[1]);
		st.out_free = !out_valid_q || res_ready;
	end

	assign res_valid = out_valid_q;
	assign res_bit_value = out_bit_q;

`ifndef SYNTHESIS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_rd && ram_we))
		else $error("node memory read and write in the same cycle");

	a_walker_internal: assert property (@(posedge clk) disable iff (!arst_n)
		act_q[0] |-> (tl_q[0] < tr_q[0]))
		else $error("active walker sits on a leaf");

	a_query_one_path: assert property (@(posedge clk) disable iff (!arst_n)
		act_q[1] |-> (kind_q != KIND_QUERY))
		else $error("second walker active during a query");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || res_ready))
		else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire
